[design/cfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CO2 frame decoder package
// Shared codes, reset values, scaling constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_ABORT = 2'd2;

    localparam logic [1:0] QTY_CO2  = 2'd0;
    localparam logic [1:0] QTY_TEMP = 2'd1;
    localparam logic [1:0] QTY_HUM  = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STATUS_DISABLED    = 2'd2;

    localparam logic [1:0] PHASE_HIGH = 2'd0;
    localparam logic [1:0] PHASE_LOW  = 2'd1;
    localparam logic [1:0] PHASE_CRC  = 2'd2;

    localparam logic [1:0] WORD_CO2  = 2'd0;
    localparam logic [1:0] WORD_TEMP = 2'd1;
    localparam logic [1:0] WORD_HUM  = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [15:0]       CO2_RESET  = 16'd400;
    localparam logic signed [14:0] TEMP_RESET = 15'sd2500;
    localparam logic [13:0]       HUM_RESET  = 14'd5000;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] ROUND_HALF  = 16'd32767;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[design/cfd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CO2 frame decoder scaling
// Converts raw temperature and humidity words to rounded centi-units.
// ----------------------------------------------------------------------------
module cfd_scale (
    input  logic [15:0]        i_temp_raw,
    input  logic [15:0]        i_hum_raw,
    output logic signed [14:0] o_temp,
    output logic [13:0]        o_hum
);

    // Division by 65535: with x = a*65536 + b, x/65535 = a + (a+b)/65535,
    // and a+b stays below twice 65535, so one compare finishes the quotient.
    logic [30:0] temp_x;
    logic [16:0] temp_sum;
    logic [14:0] temp_q;
    logic [29:0] hum_x;
    logic [16:0] hum_sum;
    logic [13:0] hum_q;

    always_comb begin
        temp_x   = 31'(i_temp_raw) * 31'(cfd_pkg::TEMP_SCALE) + 31'(cfd_pkg::ROUND_HALF);
        temp_sum = 17'(temp_x[30:16]) + 17'(temp_x[15:0]);
        temp_q   = temp_x[30:16] + 15'(temp_sum >= cfd_pkg::FULL_SCALE);
        o_temp   = $signed(temp_q - cfd_pkg::TEMP_OFFSET);

        hum_x    = 30'(i_hum_raw) * 30'(cfd_pkg::HUM_SCALE) + 30'(cfd_pkg::ROUND_HALF);
        hum_sum  = 17'(hum_x[29:16]) + 17'(hum_x[15:0]);
        hum_q    = hum_x[29:16] + 14'(hum_sum >= cfd_pkg::FULL_SCALE);
        o_hum    = hum_q;
    end

endmodule

[design/co2_sensor_frame_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CO2 sensor frame decoder core
// Decodes the nine-byte measurement response with per-word CRC-8 checks,
// keeps scaled values and answers read transactions.
// A read result is registered in the input register and then in the result register.
// Throughput: one transaction per cycle, unless a stalled output holds back a read.
// Reset (synchronous, active low) clears the enable, the frame position and
// the CRC flags and restores the stored values to 400, 2500 and 5000.
// ----------------------------------------------------------------------------
module co2_sensor_frame_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_data_byte,
    input  logic [1:0]         i_quantity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [16:0] o_value,
    output logic [1:0]         o_status,
    output logic [2:0]         o_crc_ok_flags
);

    logic              r_in_valid;
    logic [1:0]        r_func;
    logic [7:0]        r_byte;
    logic [1:0]        r_qty;

    logic              r_enabled;
    logic [1:0]        r_phase;
    logic [1:0]        r_word;
    logic [7:0]        r_hi;
    logic [7:0]        r_lo;
    logic [7:0]        r_crc;
    logic [15:0]       r_pend_co2;
    logic [15:0]       r_pend_temp;
    logic [1:0]        r_pend_ok;
    logic [15:0]       r_co2;
    logic signed [14:0] r_temp;
    logic [13:0]       r_hum;
    logic [2:0]        r_crc_flags;

    logic              r_out_valid;
    logic signed [16:0] r_value;
    logic [1:0]        r_status;
    logic [2:0]        r_flags_out;

    logic              is_read;
    logic              advance;
    logic              in_take;
    logic              crc_ok;
    logic [2:0]        frame_flags;
    logic signed [14:0] temp_scaled;
    logic [13:0]       hum_scaled;
    logic signed [16:0] n_value;
    logic [1:0]        n_status;

    cfd_scale u_scale (
        .i_temp_raw (r_pend_temp),
        .i_hum_raw  ({r_hi, r_lo}),
        .o_temp     (temp_scaled),
        .o_hum      (hum_scaled)
    );

    assign is_read     = (r_func == cfd_pkg::FUNC_READ);
    assign advance     = r_in_valid && (!is_read || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign crc_ok      = (r_crc == r_byte);
    assign frame_flags = {crc_ok, r_pend_ok};

    always_comb begin
        n_value  = '0;
        n_status = cfd_pkg::STATUS_OK;
        if (!r_enabled) begin
            n_status = cfd_pkg::STATUS_DISABLED;
        end else begin
            case (r_qty)
                cfd_pkg::QTY_CO2:  n_value = 17'($unsigned(r_co2));
                cfd_pkg::QTY_TEMP: n_value = 17'(r_temp);
                cfd_pkg::QTY_HUM:  n_value = 17'($unsigned(r_hum));
                default:           n_status = cfd_pkg::STATUS_UNSUPPORTED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_func <= i_func;
            r_byte <= i_data_byte;
            r_qty  <= i_quantity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && i_cfg_wdata)) begin
            r_enabled   <= !i_rst_n ? 1'b0 : 1'b1;
            r_phase     <= cfd_pkg::PHASE_HIGH;
            r_word      <= cfd_pkg::WORD_CO2;
            r_hi        <= '0;
            r_lo        <= '0;
            r_crc       <= cfd_pkg::CRC_INIT;
            r_pend_co2  <= '0;
            r_pend_temp <= '0;
            r_pend_ok   <= '0;
            r_co2       <= cfd_pkg::CO2_RESET;
            r_temp      <= cfd_pkg::TEMP_RESET;
            r_hum       <= cfd_pkg::HUM_RESET;
            r_crc_flags <= '0;
        end else if (i_cfg_we) begin
            r_enabled <= 1'b0;
        end else if (advance) begin
            case (r_func)
                cfd_pkg::FUNC_BYTE: begin
                    case (r_phase)
                        cfd_pkg::PHASE_HIGH: begin
                            r_hi    <= r_byte;
                            r_crc   <= cfd_pkg::crc8_byte(cfd_pkg::CRC_INIT, r_byte);
                            r_phase <= cfd_pkg::PHASE_LOW;
                        end
                        cfd_pkg::PHASE_LOW: begin
                            r_lo    <= r_byte;
                            r_crc   <= cfd_pkg::crc8_byte(r_crc, r_byte);
                            r_phase <= cfd_pkg::PHASE_CRC;
                        end
                        default: begin
                            r_phase <= cfd_pkg::PHASE_HIGH;
                            case (r_word)
                                cfd_pkg::WORD_CO2: begin
                                    r_pend_co2   <= {r_hi, r_lo};
                                    r_pend_ok[0] <= crc_ok;
                                    r_word       <= cfd_pkg::WORD_TEMP;
                                end
                                cfd_pkg::WORD_TEMP: begin
                                    r_pend_temp  <= {r_hi, r_lo};
                                    r_pend_ok[1] <= crc_ok;
                                    r_word       <= cfd_pkg::WORD_HUM;
                                end
                                default: begin
                                    if (frame_flags[0]) begin
                                        r_co2 <= r_pend_co2;
                                    end
                                    if (frame_flags[1]) begin
                                        r_temp <= temp_scaled;
                                    end
                                    if (frame_flags[2]) begin
                                        r_hum <= hum_scaled;
                                    end
                                    r_crc_flags <= frame_flags;
                                    r_pend_ok   <= '0;
                                    r_word      <= cfd_pkg::WORD_CO2;
                                end
                            endcase
                        end
                    endcase
                end
                cfd_pkg::FUNC_ABORT: begin
                    r_phase   <= cfd_pkg::PHASE_HIGH;
                    r_word    <= cfd_pkg::WORD_CO2;
                    r_pend_ok <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && is_read) begin
            r_value     <= n_value;
            r_status    <= n_status;
            r_flags_out <= r_crc_flags;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_status       = r_status;
    assign o_crc_ok_flags = r_flags_out;

endmodule
